### rtl/core/clsr_pkg.sv
`timescale 1ns / 1ps

package clsr_pkg;

    // field widths
    localparam int VAL_W  = 31;
    localparam int PROD_W = 47;            // 31-bit state times 16-bit multiplier

    // shuffle table
    localparam int TABLE_DEPTH  = 32;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int WARMUP_STEPS = 8;
    localparam int CNT_W        = $clog2(TABLE_DEPTH + WARMUP_STEPS);

    // generator constants
    localparam logic [VAL_W-1:0] MOD_ONE  = 31'd2147483563;   // 2^31 - 85
    localparam logic [VAL_W-1:0] MOD_TWO  = 31'd2147483399;   // 2^31 - 249
    localparam logic [7:0]       FOLD_ONE = 8'd85;
    localparam logic [7:0]       FOLD_TWO = 8'd249;
    localparam logic [15:0]      MUL_ONE  = 16'd40014;
    localparam logic [15:0]      MUL_TWO  = 16'd40692;
    localparam logic [VAL_W-1:0] SEED_TWO_RESET = 31'd123456789;
    localparam logic [VAL_W-1:0] OUT_SPAN = 31'd2147483562;
    localparam logic [26:0]      SLOT_DIV = 27'd67108862;     // 2^26 - 2

    // p mod m for m = 2^31 - fold, p < 2^47: fold the top bits once,
    // the sum stays below 2m so one subtract finishes it
    function automatic logic [VAL_W-1:0] mod_fold(input logic [PROD_W-1:0] p,
                                                  input logic [7:0] fold,
                                                  input logic [VAL_W-1:0] m);
        logic [31:0] s;
        s = 32'(p[PROD_W-1:VAL_W]) * 32'(fold) + 32'(p[VAL_W-1:0]);
        if (s >= 32'(m))
            s = s - 32'(m);
        return s[VAL_W-1:0];
    endfunction

    // floor(x / (2^26 - 2)) masked to the table depth
    function automatic logic [ADDR_W-1:0] slot_of(input logic [VAL_W-1:0] x);
        logic [ADDR_W-1:0] q;
        logic [26:0]       r;
        q = x[30:26];
        r = {1'b0, x[25:0]} + {21'd0, q, 1'b0};
        if (r >= SLOT_DIV)
            q = q + ADDR_W'(1);
        return q;
    endfunction

endpackage

### rtl/core/combined_lcg_shuffle_rng_top.sv
`timescale 1ns / 1ps

// Combined two-generator LCG with a 32-entry shuffle table.
// Request channel (req_valid/req_ready): operation 0 draws the next value,
// operation 1 reseeds from seed_value (zero taken as one) and then draws.
// Result channel (rsp_valid/rsp_ready): one item, random_value in
// 1..2147483562, per request item, in order.
// Steps: a draw goes from the accept through the table read and generator
// multiply, then the mod fold, then the combine, in which the result is
// registered. A reseed first runs 40 generator steps, each a
// registered multiply followed by a registered fold, writing the last 32
// into the table memory one entry per step, and then draws.
// Requests are taken one at a time; req_ready is high only while no item is
// in work. A result held by a stalled receiver does not block the next
// accept: the block stops only at its final step until the result register
// frees.
// Reset: generators to 1 and 123456789, last output to 0, and the table
// reads as all zeros through per-entry valid flags cleared at once.
module combined_lcg_shuffle_rng_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  logic                       operation,
    input  logic [clsr_pkg::VAL_W-1:0] seed_value,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output logic [clsr_pkg::VAL_W-1:0] random_value
);
    import clsr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SMUL = 3'd1;   // reseed: multiply
    localparam logic [2:0] S_SRED = 3'd2;   // reseed: fold, table fill
    localparam logic [2:0] S_DMUL = 3'd3;   // draw: multiply, table read
    localparam logic [2:0] S_DRED = 3'd4;   // draw: fold
    localparam logic [2:0] S_DOUT = 3'd5;   // draw: combine, write back

    localparam logic [CNT_W-1:0] CNT_START = CNT_W'(TABLE_DEPTH + WARMUP_STEPS - 1);

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [VAL_W-1:0]  x1_reg, x1_next;
    logic [VAL_W-1:0]  x2_reg, x2_next;
    logic [VAL_W-1:0]  last_reg, last_next;
    logic [PROD_W-1:0] prod1_reg, prod2_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [VAL_W-1:0]  rd_data_reg;
    logic              rd_valid_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic              rsp_valid_reg;
    logic [VAL_W-1:0]  rsp_data_reg;

    // table memory
    logic [VAL_W-1:0]  table_mem [TABLE_DEPTH];

    logic              req_fire;
    logic              out_free;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic [VAL_W-1:0]  red1;
    logic [VAL_W-1:0]  red2;
    logic [ADDR_W-1:0] slot;
    logic [VAL_W-1:0]  tbl_val;
    logic [32:0]       diff;
    logic [32:0]       diff_adj;
    logic [VAL_W-1:0]  result;
    logic [VAL_W-1:0]  seed_fix;

    assign req_ready    = (state_reg == S_IDLE);
    assign req_fire     = req_valid && req_ready;
    assign out_free     = !rsp_valid_reg || rsp_ready;
    assign rsp_valid    = rsp_valid_reg;
    assign random_value = rsp_data_reg;

    assign red1 = mod_fold(prod1_reg, FOLD_ONE, MOD_ONE);
    assign red2 = mod_fold(prod2_reg, FOLD_TWO, MOD_TWO);
    assign slot = slot_of(last_reg);

    assign seed_fix = (seed_value == '0) ? VAL_W'(1) : seed_value;

    // combine: table entry minus generator two, wrapped into 1..span
    assign tbl_val  = rd_valid_reg ? rd_data_reg : '0;
    assign diff     = {2'b00, tbl_val} - {2'b00, x2_reg};
    assign diff_adj = (diff[32] || diff == '0) ? diff + {2'b00, OUT_SPAN} : diff;
    assign result   = diff_adj[VAL_W-1:0];

    // table writes: fill during reseed, write-back of the new x1 on a draw
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_addr_reg;
        wr_data = x1_reg;
        if (state_reg == S_SRED && cnt_reg < CNT_W'(TABLE_DEPTH))
        begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg[ADDR_W-1:0];
            wr_data = red1;
        end
        else if (state_reg == S_DOUT && out_free)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        x1_next    = x1_reg;
        x2_next    = x2_reg;
        last_next  = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (operation)
                    begin
                        x1_next    = seed_fix;
                        x2_next    = seed_fix;
                        cnt_next   = CNT_START;
                        state_next = S_SMUL;
                    end
                    else
                    begin
                        state_next = S_DMUL;
                    end
                end
            end
            S_SMUL:
            begin
                state_next = S_SRED;
            end
            S_SRED:
            begin
                x1_next = red1;
                if (cnt_reg == '0)
                begin
                    last_next  = red1;          // slot 0 holds the last fill
                    state_next = S_DMUL;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = S_SMUL;
                end
            end
            S_DMUL:
            begin
                state_next = S_DRED;
            end
            S_DRED:
            begin
                x1_next    = red1;
                x2_next    = red2;
                state_next = S_DOUT;
            end
            S_DOUT:
            begin
                if (out_free)
                begin
                    last_next  = result;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            x1_reg        <= VAL_W'(1);
            x2_reg        <= SEED_TWO_RESET;
            last_reg      <= '0;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            x1_reg    <= x1_next;
            x2_reg    <= x2_next;
            last_reg  <= last_next;
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (state_reg == S_DOUT && out_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod1_reg <= PROD_W'(x1_reg) * PROD_W'(MUL_ONE);
        prod2_reg <= PROD_W'(x2_reg) * PROD_W'(MUL_TWO);
        if (state_reg == S_DMUL)
        begin
            rd_addr_reg  <= slot;
            rd_valid_reg <= valid_reg[slot];
        end
        if (state_reg == S_DOUT && out_free)
            rsp_data_reg <= result;
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            table_mem[wr_addr] <= wr_data;
        if (state_reg == S_DMUL)
            rd_data_reg <= table_mem[slot];
    end

    // an accepted item always leaves the idle state
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> state_reg != S_IDLE)
        else $error("block idle after accepting an item");

    // results always lie in the generator output range
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_data_reg != '0 && rsp_data_reg <= OUT_SPAN))
        else $error("result out of range");

    // final draw step waits while the result register is still occupied
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DOUT && rsp_valid_reg && !rsp_ready) |=> state_reg == S_DOUT)
        else $error("draw completed over a pending result");

    // reseed step counter stays within the warm-up plus fill length
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_START)
        else $error("reseed counter out of range");

endmodule
